[hdl/bcle_pkg.sv]
// Shared types and constants for the bounded circular list engine.
// Used by bcle_ctrl, bcle_dp and the top level; depends on nothing.
package bcle_pkg;

  // request modes
  localparam logic [3:0] MODE_INS_HEAD = 4'd0;
  localparam logic [3:0] MODE_INS_TAIL = 4'd1;
  localparam logic [3:0] MODE_INS_AT   = 4'd2;
  localparam logic [3:0] MODE_DEL_HEAD = 4'd3;
  localparam logic [3:0] MODE_DEL_TAIL = 4'd4;
  localparam logic [3:0] MODE_DEL_AT   = 4'd5;
  localparam logic [3:0] MODE_SEARCH   = 4'd6;
  localparam logic [3:0] MODE_REVERSE  = 4'd7;
  localparam logic [3:0] MODE_CLEAR    = 4'd8;

  // result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;
  localparam logic [1:0] ST_FULL  = 2'd3;

  // datapath micro-operations issued by the controller
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_DECODE,
    OP_FIND,
    OP_WALK,
    OP_BACK,
    OP_SEARCH,
    OP_SOLE,
    OP_LINK1,
    OP_LINK2,
    OP_UNLINK,
    OP_REV,
    OP_CLEAR,
    OP_OUT
  } dp_op_t;

  // controller states
  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_FIND,
    S_IBACK,
    S_IWALK,
    S_SOLE,
    S_LINK1,
    S_LINK2,
    S_DBACK,
    S_DWALK,
    S_UNLINK,
    S_SEARCH,
    S_RBACK,
    S_REV,
    S_CLEAR,
    S_DONE
  } ctl_state_t;

  // datapath status toward the controller
  typedef struct packed {
    logic is_ins;
    logic is_del;
    logic is_srch;
    logic is_rev;
    logic is_clr;
    logic err;
    logic ins_back;
    logic del_front;
    logic del_back;
    logic cnt_zero;
    logic k_zero;
    logic slot_free;
    logic match;
    logic i_last;
    logic out_free;
  } dp_flags_t;

endpackage

[hdl/bcle_ctrl.sv]
// Controller state machine of the circular list engine.
// Depends on bcle_pkg; drives bcle_dp through one micro-op per cycle.
module bcle_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_ready,
  input  bcle_pkg::dp_flags_t flags,
  output bcle_pkg::dp_op_t   op
);
  import bcle_pkg::*;

  ctl_state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (req_valid) state_next = S_DECODE;
      end
      S_DECODE: begin
        priority if (flags.err) state_next = S_DONE;
        else if (flags.is_ins) state_next = S_FIND;
        else if (flags.is_del) begin
          priority if (flags.del_front) state_next = S_UNLINK;
          else if (flags.del_back) state_next = S_DBACK;
          else state_next = S_DWALK;
        end
        else if (flags.is_srch) state_next = S_SEARCH;
        else if (flags.is_rev) state_next = S_RBACK;
        else if (flags.is_clr) state_next = S_CLEAR;
        else state_next = S_DONE;
      end
      S_FIND: begin
        if (flags.slot_free) begin
          priority if (flags.cnt_zero) state_next = S_SOLE;
          else if (flags.ins_back) state_next = S_IBACK;
          else state_next = S_IWALK;
        end
      end
      S_IBACK:  state_next = S_LINK1;
      S_IWALK: begin
        if (flags.k_zero) state_next = S_LINK1;
      end
      S_SOLE:   state_next = S_DONE;
      S_LINK1:  state_next = S_LINK2;
      S_LINK2:  state_next = S_DONE;
      S_DBACK:  state_next = S_UNLINK;
      S_DWALK: begin
        if (flags.k_zero) state_next = S_UNLINK;
      end
      S_UNLINK: state_next = S_DONE;
      S_SEARCH: begin
        if (flags.match || flags.i_last) state_next = S_DONE;
      end
      S_RBACK:  state_next = S_REV;
      S_REV:    state_next = S_DONE;
      S_CLEAR:  state_next = S_DONE;
      S_DONE: begin
        if (flags.out_free) state_next = S_IDLE;
      end
      default:  state_next = S_IDLE;
    endcase
  end

  // micro-op per state
  always_comb begin
    op = OP_NONE;
    unique case (state)
      S_IDLE:   op = req_valid ? OP_LOAD : OP_NONE;
      S_DECODE: op = OP_DECODE;
      S_FIND:   op = OP_FIND;
      S_IBACK:  op = OP_BACK;
      S_IWALK:  op = flags.k_zero ? OP_NONE : OP_WALK;
      S_SOLE:   op = OP_SOLE;
      S_LINK1:  op = OP_LINK1;
      S_LINK2:  op = OP_LINK2;
      S_DBACK:  op = OP_BACK;
      S_DWALK:  op = flags.k_zero ? OP_NONE : OP_WALK;
      S_UNLINK: op = OP_UNLINK;
      S_SEARCH: op = OP_SEARCH;
      S_RBACK:  op = OP_BACK;
      S_REV:    op = OP_REV;
      S_CLEAR:  op = OP_CLEAR;
      S_DONE:   op = flags.out_free ? OP_OUT : OP_NONE;
      default:  op = OP_NONE;
    endcase
  end

  assign req_ready = (state == S_IDLE);

endmodule

[hdl/bcle_dp.sv]
// Datapath of the circular list engine: node memories, link walker,
// free-slot scanner, list registers and the result register. Uses bcle_pkg.
module bcle_dp #(
  parameter int CAPACITY    = 256,
  parameter int VALUE_WIDTH = 32,
  parameter int SLOT_W      = 8,
  parameter int CNT_W       = 9
) (
  input  logic                clk,
  input  logic                rst,
  input  bcle_pkg::dp_op_t    op,
  output bcle_pkg::dp_flags_t flags,
  input  logic [3:0]          req_mode,
  input  logic signed [31:0]  req_value,
  input  logic [15:0]         req_position,
  output logic                res_valid,
  input  logic                res_ready,
  output logic [1:0]          res_status,
  output logic                res_found,
  output logic [CNT_W-1:0]    res_fpos,
  output logic [CNT_W-1:0]    res_count
);
  import bcle_pkg::*;

  // node memories
  logic [VALUE_WIDTH-1:0] elem_mem [CAPACITY];
  logic [SLOT_W-1:0]      fwd_mem  [CAPACITY];
  logic [SLOT_W-1:0]      bwd_mem  [CAPACITY];
  logic [CAPACITY-1:0]    in_use;

  // list and work registers
  logic [SLOT_W-1:0]      head, p, n, b;
  logic                   rev;
  logic [CNT_W-1:0]       count, k, i;
  logic [3:0]             mode;
  logic [VALUE_WIDTH-1:0] val;
  logic [15:0]            pos;
  logic [1:0]             st;
  logic                   found;
  logic [CNT_W-1:0]       fpos;

  // read port
  logic [VALUE_WIDTH-1:0] rd_elem;
  logic [SLOT_W-1:0]      rd_fwd, rd_bwd, rd_nxt, rd_prv, rd_addr;
  logic                   rd_en;

  // logical link write ports, mapped through the direction flag
  logic                   nw_en, pw_en;
  logic [SLOT_W-1:0]      nw_addr, nw_data, pw_addr, pw_data;
  logic                   fw_en, bw_en, ew_en;
  logic [SLOT_W-1:0]      fw_addr, fw_data, bw_addr, bw_data;

  logic signed [63:0]     val_ext;
  logic [16:0]            pos_x, cnt_x;
  logic [1:0]             st_c;
  logic                   is_ins, is_del, full;

  assign rd_nxt  = rev ? rd_bwd : rd_fwd;
  assign rd_prv  = rev ? rd_fwd : rd_bwd;
  assign val_ext = 64'(req_value);

  // request checks
  assign pos_x  = {1'b0, pos};
  assign cnt_x  = 17'(count);
  assign is_ins = (mode == MODE_INS_HEAD) || (mode == MODE_INS_TAIL) ||
                  (mode == MODE_INS_AT);
  assign is_del = (mode == MODE_DEL_HEAD) || (mode == MODE_DEL_TAIL) ||
                  (mode == MODE_DEL_AT);
  assign full   = (count == CNT_W'(CAPACITY));

  always_comb begin
    st_c = ST_OK;
    priority if (is_ins) begin
      priority if (full) st_c = ST_FULL;
      else if (mode == MODE_INS_AT && count != '0 &&
               (pos == 16'd0 || pos_x > cnt_x + 17'd1)) st_c = ST_RANGE;
    end
    else if (is_del) begin
      priority if (count == '0) st_c = ST_EMPTY;
      else if (mode == MODE_DEL_AT && (pos == 16'd0 || pos_x > cnt_x))
        st_c = ST_RANGE;
    end
    else if (mode == MODE_SEARCH || mode == MODE_REVERSE) begin
      if (count == '0) st_c = ST_EMPTY;
    end
  end

  // status toward the controller
  always_comb begin
    flags.is_ins    = is_ins;
    flags.is_del    = is_del;
    flags.is_srch   = (mode == MODE_SEARCH);
    flags.is_rev    = (mode == MODE_REVERSE);
    flags.is_clr    = (mode == MODE_CLEAR);
    flags.err       = (st_c != ST_OK);
    flags.ins_back  = (mode == MODE_INS_HEAD) || (mode == MODE_INS_TAIL) ||
                      (pos == 16'd1);
    flags.del_front = (mode == MODE_DEL_HEAD);
    flags.del_back  = (mode == MODE_DEL_TAIL);
    flags.cnt_zero  = (count == '0);
    flags.k_zero    = (k == '0);
    flags.slot_free = !in_use[n];
    flags.match     = (rd_elem == val);
    flags.i_last    = (i == count);
    flags.out_free  = !res_valid || res_ready;
  end

  // read address select
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = head;
    unique case (op)
      OP_LOAD:           begin rd_en = 1'b1; rd_addr = head;   end
      OP_WALK:           begin rd_en = 1'b1; rd_addr = rd_nxt; end
      OP_SEARCH:         begin rd_en = !flags.match; rd_addr = rd_nxt; end
      OP_BACK:           begin rd_en = 1'b1; rd_addr = rd_prv; end
      default:           begin rd_en = 1'b0; rd_addr = head;   end
    endcase
  end

  // link writes in list order, then swapped by direction
  always_comb begin
    nw_en = 1'b0; nw_addr = p; nw_data = n;
    pw_en = 1'b0; pw_addr = n; pw_data = p;
    ew_en = 1'b0;
    unique case (op)
      OP_LINK1: begin
        ew_en = 1'b1;
        nw_en = 1'b1; nw_addr = p; nw_data = n;
        pw_en = 1'b1; pw_addr = n; pw_data = p;
      end
      OP_LINK2: begin
        nw_en = 1'b1; nw_addr = n; nw_data = b;
        pw_en = 1'b1; pw_addr = b; pw_data = n;
      end
      OP_UNLINK: begin
        nw_en = (count != CNT_W'(1)); nw_addr = rd_prv; nw_data = rd_nxt;
        pw_en = (count != CNT_W'(1)); pw_addr = rd_nxt; pw_data = rd_prv;
      end
      OP_SOLE: begin
        ew_en = 1'b1;
        nw_en = 1'b1; nw_addr = n; nw_data = n;
        pw_en = 1'b1; pw_addr = n; pw_data = n;
      end
      default: begin
        nw_en = 1'b0;
        pw_en = 1'b0;
      end
    endcase
  end

  assign fw_en   = rev ? pw_en   : nw_en;
  assign fw_addr = rev ? pw_addr : nw_addr;
  assign fw_data = rev ? pw_data : nw_data;
  assign bw_en   = rev ? nw_en   : pw_en;
  assign bw_addr = rev ? nw_addr : pw_addr;
  assign bw_data = rev ? nw_data : pw_data;

  // memories: one write and one registered read each
  always_ff @(posedge clk) begin
    if (ew_en) elem_mem[n] <= val;
    if (fw_en) fwd_mem[fw_addr] <= fw_data;
    if (bw_en) bwd_mem[bw_addr] <= bw_data;
    if (rd_en) begin
      rd_elem <= elem_mem[rd_addr];
      rd_fwd  <= fwd_mem[rd_addr];
      rd_bwd  <= bwd_mem[rd_addr];
    end
  end

  // request and work registers
  always_ff @(posedge clk) begin
    unique case (op)
      OP_LOAD: begin
        mode  <= req_mode;
        val   <= val_ext[VALUE_WIDTH-1:0];
        pos   <= req_position;
        p     <= head;
        n     <= '0;
        i     <= CNT_W'(1);
        found <= 1'b0;
        fpos  <= '0;
      end
      OP_DECODE: begin
        st <= st_c;
        k  <= (mode == MODE_INS_AT) ? CNT_W'(pos - 16'd2) : CNT_W'(pos - 16'd1);
      end
      OP_FIND: begin
        if (in_use[n]) n <= n + SLOT_W'(1);
      end
      OP_WALK: begin
        p <= rd_nxt;
        k <= k - CNT_W'(1);
      end
      OP_BACK: p <= rd_prv;
      OP_SEARCH: begin
        if (flags.match) begin
          found <= 1'b1;
          fpos  <= i;
        end else begin
          p <= rd_nxt;
          i <= i + CNT_W'(1);
        end
      end
      OP_LINK1: b <= rd_nxt;
      default: ;
    endcase
  end

  // list state
  always_ff @(posedge clk) begin
    if (rst) begin
      in_use <= '0;
      head   <= '0;
      rev    <= 1'b0;
      count  <= '0;
    end else begin
      unique case (op)
        OP_SOLE: begin
          in_use[n] <= 1'b1;
          head      <= n;
          count     <= count + CNT_W'(1);
        end
        OP_LINK1: in_use[n] <= 1'b1;
        OP_LINK2: begin
          count <= count + CNT_W'(1);
          if (mode == MODE_INS_HEAD || (mode == MODE_INS_AT && pos == 16'd1))
            head <= n;
        end
        OP_UNLINK: begin
          in_use[p] <= 1'b0;
          count     <= count - CNT_W'(1);
          if (count == CNT_W'(1)) begin
            head <= '0;
            rev  <= 1'b0;
          end else if (p == head) begin
            head <= rd_nxt;
          end
        end
        OP_REV: begin
          head <= p;
          rev  <= !rev;
        end
        OP_CLEAR: begin
          in_use <= '0;
          head   <= '0;
          rev    <= 1'b0;
          count  <= '0;
        end
        default: ;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (op == OP_OUT) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (op == OP_OUT) begin
      res_status <= st;
      res_found  <= found;
      res_fpos   <= fpos;
      res_count  <= count;
    end
  end

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("element count above capacity");

  a_out_free: assert property (@(posedge clk) disable iff (rst)
    (op == OP_OUT) |-> (!res_valid || res_ready))
    else $error("result loaded over a pending result");

  a_clear: assert property (@(posedge clk) disable iff (rst)
    (op == OP_CLEAR) |=> (count == '0 && !rev))
    else $error("clear left elements behind");

  a_rev_empty: assert property (@(posedge clk) disable iff (rst)
    (count == '0) |-> !rev)
    else $error("direction flag set on empty list");

endmodule

[hdl/bounded_circular_list_engine_top.sv]
// Circular doubly linked list engine, one request at a time.
// A request is loaded on acceptance, decoded and checked, then processed; its result is
// loaded into the result register once that register is free.
// Inserts add a free-slot scan of one slot per cycle; positional ops walk one element per cycle.
// A held result stalls the input: no new request is taken until the result is loaded.
// Reset clears the list, every slot flag and the result valid flag at once.
module bounded_circular_list_engine_top #(
  parameter int CAPACITY    = 256,
  parameter int VALUE_WIDTH = 32
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  // mode[3:0], value[35:4], position[51:36], zero pad
  input  logic [55:0] s_tdata,
  output logic m_tvalid,
  input  logic m_tready,
  // status[1:0], found[2], found_position, element_count, zero pad
  output logic [((3 + 2*$clog2(CAPACITY+1) + 7) / 8) * 8 - 1:0] m_tdata
);
  import bcle_pkg::*;

  localparam int SLOT_W = $clog2(CAPACITY);
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int OUT_W  = ((3 + 2*CNT_W + 7) / 8) * 8;
  localparam int PAD_W  = OUT_W - (3 + 2*CNT_W);

  dp_op_t     op;
  dp_flags_t  flags;
  logic [1:0] res_status;
  logic       res_found;
  logic [CNT_W-1:0] res_fpos, res_count;

  bcle_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (s_tvalid),
    .req_ready (s_tready),
    .flags     (flags),
    .op        (op)
  );

  bcle_dp #(
    .CAPACITY    (CAPACITY),
    .VALUE_WIDTH (VALUE_WIDTH),
    .SLOT_W      (SLOT_W),
    .CNT_W       (CNT_W)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .op           (op),
    .flags        (flags),
    .req_mode     (s_tdata[3:0]),
    .req_value    (s_tdata[35:4]),
    .req_position (s_tdata[51:36]),
    .res_valid    (m_tvalid),
    .res_ready    (m_tready),
    .res_status   (res_status),
    .res_found    (res_found),
    .res_fpos     (res_fpos),
    .res_count    (res_count)
  );

  // pack result fields
  assign m_tdata = {{PAD_W{1'b0}}, res_count, res_fpos, res_found, res_status};

endmodule
